// ===== rtl/core/bdq_pkg.sv =====
// shared types, codes and defaults for the bounded deque
package bdq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 3;
  localparam int CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [ACTION_W-1:0] ACT_PUSH_LEFT  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_RIGHT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_LEFT   = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_RIGHT  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_PUSHED_LEFT  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PUSHED_RIGHT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POPPED_LEFT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_POPPED_RIGHT = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL         = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY        = 3'd5;

  // broadcast to every cell of the row
  typedef struct packed {
    logic shift_right;  // push left: every entry moves one cell to the right
    logic shift_left;   // pop left: every entry moves one cell to the left
    logic wr_tail;      // push right: the first free cell takes the value
  } bdq_ctrl_t;

endpackage

// ===== rtl/core/bdq_cell.sv =====
// one storage cell of the deque row, trading entries with its neighbours
module bdq_cell
  import bdq_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  bdq_ctrl_t             ctrl,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] left_in,
  input  logic [DATA_WIDTH-1:0] right_in,
  input  logic [DATA_WIDTH-1:0] wr_data,
  output logic [DATA_WIDTH-1:0] data,
  output logic [DATA_WIDTH-1:0] tail_tap
);

  logic is_free_head;
  logic is_last;

  assign is_free_head = (count == CNT_W'(IDX));
  assign is_last      = (count == CNT_W'(IDX + 1));

  always_ff @(posedge clk) begin
    if (ctrl.shift_right) begin
      data <= left_in;
    end else if (ctrl.shift_left) begin
      data <= right_in;
    end else if (ctrl.wr_tail && is_free_head) begin
      data <= wr_data;
    end
  end

  // only the rightmost held entry shows on the tap
  assign tail_tap = is_last ? data : '0;

endmodule

// ===== rtl/core/bounded_deque.sv =====
// bounded deque top level: control, occupancy, result register and the cell row
//
// A bounded double-ended queue built as a row of DEPTH cells, entry 0 always
// at the left end. Each request (push left, push right, pop left, pop right)
// is accepted and its result appears in the output register in the
// next cycle, so a new request can be accepted every cycle while the
// consumer keeps stall low. Push left and pop left shift the whole row by
// one cell; push right writes the first free cell; pop right picks the last
// held cell through a select across the row. A push when the count has
// reached min(capacity, DEPTH) answers full, a pop on an empty deque answers
// empty, both with zero data. The capacity register resets to 16 and may be
// written only while no request is in flight.
module bounded_deque
  import bdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [CAP_W-1:0]           cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [ACTION_W-1:0]        action,
  input  logic signed [VALUE_W-1:0]  value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        status,
  output logic signed [VALUE_W-1:0]  data_out
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0]      capacity;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  accept;
  logic                  is_push;
  logic                  is_full;
  logic                  is_empty;
  logic                  push_ok;
  logic                  pop_ok;
  bdq_ctrl_t             ctrl;
  logic [DATA_WIDTH-1:0] store_val;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] cell_tap  [DEPTH];
  logic [DATA_WIDTH-1:0] tail_data;
  logic [VALUE_W-1:0]    tail_wide;
  logic [VALUE_W-1:0]    head_wide;
  logic [STATUS_W-1:0]   status_next;
  logic [VALUE_W-1:0]    data_next;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_push  = (action == ACT_PUSH_LEFT) || (action == ACT_PUSH_RIGHT);
  assign is_full  = (CMP_W'(count) >= CMP_W'(capacity)) || (count == CNT_W'(DEPTH));
  assign is_empty = (count == '0);
  assign push_ok  = accept && is_push && !is_full;
  assign pop_ok   = accept && !is_push && !is_empty;

  assign ctrl.shift_right = push_ok && (action == ACT_PUSH_LEFT);
  assign ctrl.shift_left  = pop_ok && (action == ACT_POP_LEFT);
  assign ctrl.wr_tail     = push_ok && (action == ACT_PUSH_RIGHT);

  // words narrower than VALUE_W keep the low bits on push and are sign-extended on pop
  generate
    if (DATA_WIDTH >= VALUE_W) begin : g_wide
      assign store_val = DATA_WIDTH'(value);
      assign tail_wide = tail_data[VALUE_W-1:0];
      assign head_wide = cell_data[0][VALUE_W-1:0];
    end else begin : g_narrow
      assign store_val = value[DATA_WIDTH-1:0];
      assign tail_wide = {{(VALUE_W - DATA_WIDTH){tail_data[DATA_WIDTH-1]}}, tail_data};
      assign head_wide = {{(VALUE_W - DATA_WIDTH){cell_data[0][DATA_WIDTH-1]}}, cell_data[0]};
    end
  endgenerate

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_in;
      logic [DATA_WIDTH-1:0] right_in;
      if (i == 0) begin : g_first
        assign left_in = store_val;
      end else begin : g_mid_l
        assign left_in = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right_in = '0;
      end else begin : g_mid_r
        assign right_in = cell_data[i+1];
      end
      bdq_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W),
        .IDX        (i)
      ) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .count    (count),
        .left_in  (left_in),
        .right_in (right_in),
        .wr_data  (store_val),
        .data     (cell_data[i]),
        .tail_tap (cell_tap[i])
      );
    end
  endgenerate

  // at most one tap is live, so an or across the row selects the tail
  always_comb begin
    tail_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      tail_data = tail_data | cell_tap[i];
    end
  end

  always_comb begin
    count_next  = count;
    status_next = ST_EMPTY;
    data_next   = '0;
    if (is_push) begin
      if (is_full) begin
        status_next = ST_FULL;
      end else begin
        count_next  = count + CNT_W'(1);
        status_next = (action == ACT_PUSH_LEFT) ? ST_PUSHED_LEFT : ST_PUSHED_RIGHT;
        data_next   = value;
      end
    end else if (!is_empty) begin
      count_next = count - CNT_W'(1);
      if (action == ACT_POP_LEFT) begin
        status_next = ST_POPPED_LEFT;
        data_next   = head_wide;
      end else begin
        status_next = ST_POPPED_RIGHT;
        data_next   = tail_wide;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status   <= status_next;
      data_out <= data_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  assert property (@(posedge clk) disable iff (rst)
    (accept && !is_push && is_empty) |=> (out_valid && status == ST_EMPTY && data_out == '0))
    else $error("pop on empty deque did not answer empty");

  assert property (@(posedge clk) disable iff (rst)
    push_ok |=> (count == $past(count) + CNT_W'(1)))
    else $error("successful push did not grow occupancy");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && !accept) |=> (out_valid && $stable(status) && $stable(data_out)))
    else $error("held result changed under stall");

endmodule
